>>> rtl/signed_number_to_lcd_segment_writes_macros.svh
// assertion macros for the signed number to lcd segment writes block
// no dependencies; the including module must provide clk and rst
`ifndef SIGNED_NUMBER_TO_LCD_SEGMENT_WRITES_MACROS_SVH
`define SIGNED_NUMBER_TO_LCD_SEGMENT_WRITES_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SNLCD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("snlcd same-cycle check failed");

// next-cycle implication
`define SNLCD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("snlcd next-cycle check failed");

`else

`define SNLCD_ASSERT_IMP(name, ante, cons)

`define SNLCD_ASSERT_NXT(name, ante, cons)

`endif

`endif

>>> rtl/snlcd_pkg.sv
// shared types, constants and segment tables for the lcd segment writer
// no dependencies
`default_nettype none

package snlcd_pkg;

  localparam int DIGIT_COUNT = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam int VALUE_W = 21;
  localparam int MAG_W   = 20;
  localparam int PC_W    = 5;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 21'sd999999;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -21'sd99999;

  // floor(2^20 / 10), quotient estimate is low by at most one
  localparam logic [16:0] RECIP_10   = 17'd104857;
  localparam int          RECIP_SHIFT = 20;

  typedef logic [3:0] glyph_t;
  localparam glyph_t GLYPH_BLANK = 4'd10;
  localparam glyph_t GLYPH_MINUS = 4'd11;

  localparam logic [PC_W-1:0] PLACES_MIN = 5'd1;
  localparam logic [PC_W-1:0] PLACES_MAX = 5'd5;
  localparam logic [PC_W-1:0] FLASH_BASE = 5'd20;
  localparam logic [PC_W-1:0] FLASH_LAST = 5'd25;

  localparam logic [2:0] NO_POINT_POS  = 3'd5;
  localparam logic [2:0] CAL_POINT_POS = 3'd3;

  typedef enum logic [1:0] {
    MODE_LIVE     = 2'd0,
    MODE_HIDE     = 2'd1,
    MODE_CAL      = 2'd2,
    MODE_HIDE_ALT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIGIT,
    F_PUSH
  } front_state_t;

  // write slots in emission order
  localparam logic [2:0] SLOT_D0    = 3'd0;
  localparam logic [2:0] SLOT_D1    = 3'd1;
  localparam logic [2:0] SLOT_D2_LO = 3'd2;
  localparam logic [2:0] SLOT_D2_HI = 3'd3;
  localparam logic [2:0] SLOT_D3    = 3'd4;
  localparam logic [2:0] SLOT_D4    = 3'd5;
  localparam logic [2:0] SLOT_D5    = 3'd6;

  localparam logic [5:0] ADDR_D0    = 6'd18;
  localparam logic [5:0] ADDR_D1    = 6'd20;
  localparam logic [5:0] ADDR_D2_LO = 6'd22;
  localparam logic [5:0] ADDR_D2_HI = 6'd17;
  localparam logic [5:0] ADDR_D3    = 6'd15;
  localparam logic [5:0] ADDR_D4    = 6'd13;
  localparam logic [5:0] ADDR_D5    = 6'd11;

  localparam logic [7:0] PT_BIT_A = 8'h10;
  localparam logic [7:0] PT_BIT_B = 8'h01;

  typedef struct packed {
    glyph_t [DIGIT_COUNT-1:0] glyphs;
    logic   [2:0]             point_pos;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [5:0] addr;
    logic [7:0] data;
    logic       nib;
  } wr_t;

  function automatic logic [7:0] seg_a(input glyph_t g);
    logic [7:0] s;
    case (g)
      4'd0:        s = 8'hEB;
      4'd1:        s = 8'h60;
      4'd2:        s = 8'hC7;
      4'd3:        s = 8'hE5;
      4'd4:        s = 8'h6C;
      4'd5:        s = 8'hAD;
      4'd6:        s = 8'hAF;
      4'd7:        s = 8'hE0;
      4'd8:        s = 8'hEF;
      4'd9:        s = 8'hED;
      GLYPH_MINUS: s = 8'h04;
      default:     s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] seg_b(input glyph_t g);
    logic [7:0] s;
    case (g)
      4'd0:        s = 8'hBE;
      4'd1:        s = 8'h06;
      4'd2:        s = 8'h7C;
      4'd3:        s = 8'h5E;
      4'd4:        s = 8'hC6;
      4'd5:        s = 8'hDA;
      4'd6:        s = 8'hFA;
      4'd7:        s = 8'h0E;
      4'd8:        s = 8'hFE;
      4'd9:        s = 8'hDE;
      GLYPH_MINUS: s = 8'h40;
      default:     s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/signed_number_to_lcd_segment_writes.sv
// Signed number to LCD segment writes: turns a signed value and a point code
// into display memory writes for a six digit segment LCD.
// Input channel (in_valid/in_stall, value, point_code): a transfer happens
// when in_valid is high and in_stall low. Output channel (out_valid/out_stall,
// lcd_address, segment_data, nibble_write, last_write): one transfer per
// display write, seven to nine per number, last_write on the final one.
// Configuration: cfg_valid/cfg_ready with screen_mode data, always ready;
// write it only while no number is in flight.
// First write path: digit extraction in the front end, the queue, then the output register.
// Throughput: the front end extracts one digit per cycle through the divide-by-ten unit,
// then hands the number off in its push state, where it can already take the next one; the back end
// gives one write per cycle through its output register while out_stall is low and the queue
// holds a number, and the write count per number sets the sustained rate.
// A queue of QUEUE_DEPTH classified numbers sits between the two halves.
// Reset: synchronous; empties the queue, drops any output and sets
// screen_mode to 0. No clearing pass is needed.
// Output stall: the pending write holds, the queue fills, then in_stall rises.
`default_nettype none

module signed_number_to_lcd_segment_writes #(
  parameter int QUEUE_DEPTH = snlcd_pkg::QUEUE_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [1:0]                        screen_mode,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  signed [snlcd_pkg::VALUE_W-1:0] value,
  input  wire  [snlcd_pkg::PC_W-1:0]        point_code,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [5:0]                        lcd_address,
  output logic [7:0]                        segment_data,
  output logic                              nibble_write,
  output logic                              last_write
);

`include "signed_number_to_lcd_segment_writes_macros.svh"

  snlcd_pkg::mode_t   mode;
  snlcd_pkg::rec_t    push_rec;
  snlcd_pkg::rec_t    head;
  snlcd_pkg::q_stat_t q_stat;
  logic               q_push;
  logic               q_pop;
  logic               lo_nib_xfer;
  logic               hi_nib_shown;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= snlcd_pkg::MODE_LIVE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= snlcd_pkg::mode_t'(screen_mode);
    end
  end

  snlcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .point_code (point_code),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_rec   (push_rec)
  );

  snlcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  snlcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lcd_address  (lcd_address),
    .segment_data (segment_data),
    .nibble_write (nibble_write),
    .last_write   (last_write)
  );

  assign lo_nib_xfer  = out_valid && !out_stall && (lcd_address == snlcd_pkg::ADDR_D2_LO);
  assign hi_nib_shown = out_valid && (lcd_address == snlcd_pkg::ADDR_D2_HI) && nibble_write;

  // front is busy extracting digits right after a transfer
  `SNLCD_ASSERT_NXT(a_front_busy, in_valid && !in_stall, in_stall)
  // low nibble of digit 2 is always followed at once by its high nibble
  `SNLCD_ASSERT_NXT(a_nibble_pair, lo_nib_xfer, hi_nib_shown)
  // a queue entry is released only with its final write
  `SNLCD_ASSERT_NXT(a_pop_last, q_pop, out_valid && last_write)

endmodule

`default_nettype wire

>>> rtl/snlcd_queue.sv
// short first-word-fall-through queue of classified numbers
// depends on snlcd_pkg for the record type
`default_nettype none

module snlcd_queue #(
  parameter int DEPTH = snlcd_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  snlcd_pkg::rec_t      push_rec,
  input  wire                  pop,
  output snlcd_pkg::rec_t      head,
  output snlcd_pkg::q_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  snlcd_pkg::rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

>>> rtl/snlcd_front.sv
// front end: saturates the value, extracts one decimal digit per cycle,
// blanks leading zeros, places the minus sign and flash blank; uses snlcd_pkg
`default_nettype none

module snlcd_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  signed [snlcd_pkg::VALUE_W-1:0] value,
  input  wire  [snlcd_pkg::PC_W-1:0]       point_code,
  input  snlcd_pkg::q_stat_t               q_stat,
  output logic                             push,
  output snlcd_pkg::rec_t                  push_rec
);

  localparam int DC = snlcd_pkg::DIGIT_COUNT;

  snlcd_pkg::front_state_t state;
  snlcd_pkg::front_state_t state_next;

  logic [snlcd_pkg::MAG_W-1:0] rem;
  logic                        neg;
  logic [snlcd_pkg::PC_W-1:0]  pc;
  logic [2:0]                  idx;
  snlcd_pkg::glyph_t           glyph [DC];

  logic                               accept;
  logic signed [snlcd_pkg::VALUE_W-1:0] vclamp;
  logic [snlcd_pkg::VALUE_W-1:0]      mag_full;

  logic [36:0] prod;
  logic [16:0] q0;
  logic [20:0] rmul;
  logic [20:0] r0_full;
  logic [4:0]  r0;
  logic [16:0] quot;
  logic [3:0]  digit;
  logic [4:0]  reach;
  logic        lead_blank;

  logic       found;
  logic [2:0] hb;
  logic [4:0] flash_off;
  logic [4:0] pp_off;

  // saturate and take magnitude
  always_comb begin
    if (value > snlcd_pkg::VALUE_MAX) begin
      vclamp = snlcd_pkg::VALUE_MAX;
    end else if (value < snlcd_pkg::VALUE_MIN) begin
      vclamp = snlcd_pkg::VALUE_MIN;
    end else begin
      vclamp = value;
    end
    mag_full = vclamp[snlcd_pkg::VALUE_W-1] ? 21'(-vclamp) : 21'(vclamp);
  end

  // divide by ten through reciprocal, one correction step
  always_comb begin
    prod    = 37'(rem) * 37'(snlcd_pkg::RECIP_10);
    q0      = prod[36:snlcd_pkg::RECIP_SHIFT];
    rmul    = 21'({q0, 3'b000}) + 21'({q0, 1'b0});
    r0_full = 21'(rem) - rmul;
    r0      = r0_full[4:0];
    if (r0 >= 5'd10) begin
      quot  = q0 + 1'b1;
      digit = 4'(r0 - 5'd10);
    end else begin
      quot  = q0;
      digit = r0[3:0];
    end
    reach      = 5'(DC - 1) - {2'b00, idx};
    lead_blank = (rem == '0) && (pc < reach);
  end

  assign push   = (state == snlcd_pkg::F_PUSH) && !q_stat.full;
  assign accept = in_valid && !in_stall;

  always_comb begin
    in_stall   = !((state == snlcd_pkg::F_IDLE) || push);
    state_next = state;
    case (state)
      snlcd_pkg::F_IDLE: begin
        if (accept) begin
          state_next = snlcd_pkg::F_DIGIT;
        end
      end
      snlcd_pkg::F_DIGIT: begin
        if (idx == '0) begin
          state_next = snlcd_pkg::F_PUSH;
        end
      end
      snlcd_pkg::F_PUSH: begin
        if (accept) begin
          state_next = snlcd_pkg::F_DIGIT;
        end else if (push) begin
          state_next = snlcd_pkg::F_IDLE;
        end
      end
      default: state_next = snlcd_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snlcd_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem <= mag_full[snlcd_pkg::MAG_W-1:0];
      neg <= vclamp[snlcd_pkg::VALUE_W-1];
      pc  <= point_code;
      idx <= 3'(DC - 1);
    end else if (state == snlcd_pkg::F_DIGIT) begin
      rem        <= 20'(quot);
      idx        <= idx - 1'b1;
      glyph[idx] <= lead_blank ? snlcd_pkg::GLYPH_BLANK : digit;
    end
  end

  // finalize: minus at the highest blank, flash blank, point position
  always_comb begin
    found = 1'b0;
    hb    = '0;
    for (int i = 0; i < DC; i++) begin
      push_rec.glyphs[i] = glyph[i];
      if (glyph[i] == snlcd_pkg::GLYPH_BLANK) begin
        found = 1'b1;
        hb    = 3'(i);
      end
    end
    if (neg) begin
      push_rec.glyphs[found ? hb : 3'd0] = snlcd_pkg::GLYPH_MINUS;
    end
    flash_off = pc - snlcd_pkg::FLASH_BASE;
    if (pc inside {[snlcd_pkg::FLASH_BASE:snlcd_pkg::FLASH_LAST]}) begin
      push_rec.glyphs[flash_off[2:0]] = snlcd_pkg::GLYPH_BLANK;
    end
    pp_off = 5'(DC - 1) - pc;
    if (pc inside {[snlcd_pkg::PLACES_MIN:snlcd_pkg::PLACES_MAX]}) begin
      push_rec.point_pos = pp_off[2:0];
    end else begin
      push_rec.point_pos = snlcd_pkg::NO_POINT_POS;
    end
  end

endmodule

`default_nettype wire

>>> rtl/snlcd_back.sv
// back end: walks the queue head through its display writes, one per cycle while out_stall
// is low, into a registered output; uses snlcd_pkg tables and addresses
`default_nettype none

module snlcd_back (
  input  wire                clk,
  input  wire                rst,
  input  snlcd_pkg::mode_t   mode,
  input  snlcd_pkg::rec_t    head,
  input  snlcd_pkg::q_stat_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [5:0]         lcd_address,
  output logic [7:0]         segment_data,
  output logic               nibble_write,
  output logic               last_write
);

  logic [2:0] slot;
  logic       pt_phase;

  logic       load;
  logic [2:0] eff_pp;
  logic       show_pt;
  logic [2:0] pt_start;
  logic [2:0] pt_end;
  logic       is_last;
  snlcd_pkg::wr_t wr;

  function automatic snlcd_pkg::wr_t make_write(
    input snlcd_pkg::rec_t r,
    input logic [2:0]      s,
    input logic            pt
  );
    snlcd_pkg::wr_t w;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] a2;
    pa = pt ? snlcd_pkg::PT_BIT_A : 8'h00;
    pb = pt ? snlcd_pkg::PT_BIT_B : 8'h00;
    a2 = snlcd_pkg::seg_a(r.glyphs[2]) | pa;
    w.nib = 1'b0;
    case (s)
      snlcd_pkg::SLOT_D0: begin
        w.addr = snlcd_pkg::ADDR_D0;
        w.data = snlcd_pkg::seg_a(r.glyphs[0]) | pa;
      end
      snlcd_pkg::SLOT_D1: begin
        w.addr = snlcd_pkg::ADDR_D1;
        w.data = snlcd_pkg::seg_a(r.glyphs[1]) | pa;
      end
      snlcd_pkg::SLOT_D2_LO: begin
        w.addr = snlcd_pkg::ADDR_D2_LO;
        w.data = {4'h0, a2[3:0]};
        w.nib  = 1'b1;
      end
      snlcd_pkg::SLOT_D2_HI: begin
        w.addr = snlcd_pkg::ADDR_D2_HI;
        w.data = {4'h0, a2[7:4]};
        w.nib  = 1'b1;
      end
      snlcd_pkg::SLOT_D3: begin
        w.addr = snlcd_pkg::ADDR_D3;
        w.data = snlcd_pkg::seg_b(r.glyphs[3]) | pb;
      end
      snlcd_pkg::SLOT_D4: begin
        w.addr = snlcd_pkg::ADDR_D4;
        w.data = snlcd_pkg::seg_b(r.glyphs[4]) | pb;
      end
      default: begin
        w.addr = snlcd_pkg::ADDR_D5;
        w.data = snlcd_pkg::seg_b(r.glyphs[5]) | pb;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    eff_pp  = (mode == snlcd_pkg::MODE_CAL) ? snlcd_pkg::CAL_POINT_POS : head.point_pos;
    show_pt = ((mode == snlcd_pkg::MODE_LIVE) || (mode == snlcd_pkg::MODE_CAL))
              && (eff_pp != snlcd_pkg::NO_POINT_POS);
    case (eff_pp)
      3'd0:    pt_start = snlcd_pkg::SLOT_D0;
      3'd1:    pt_start = snlcd_pkg::SLOT_D1;
      3'd2:    pt_start = snlcd_pkg::SLOT_D2_LO;
      3'd3:    pt_start = snlcd_pkg::SLOT_D3;
      default: pt_start = snlcd_pkg::SLOT_D4;
    endcase
    // digit 2 is split over two nibble writes
    pt_end  = (pt_start == snlcd_pkg::SLOT_D2_LO) ? snlcd_pkg::SLOT_D2_HI : pt_start;
    is_last = pt_phase ? (slot == pt_end) : ((slot == snlcd_pkg::SLOT_D5) && !show_pt);
    load    = !q_stat.empty && (!out_valid || !out_stall);
    pop     = load && is_last;
    wr      = make_write(head, slot, pt_phase);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= snlcd_pkg::SLOT_D0;
      pt_phase  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (is_last) begin
          slot     <= snlcd_pkg::SLOT_D0;
          pt_phase <= 1'b0;
        end else if (!pt_phase && (slot == snlcd_pkg::SLOT_D5)) begin
          slot     <= pt_start;
          pt_phase <= 1'b1;
        end else begin
          slot <= slot + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lcd_address  <= wr.addr;
      segment_data <= wr.data;
      nibble_write <= wr.nib;
      last_write   <= is_last;
    end
  end

endmodule

`default_nettype wire

>>> dv/lcd_write_check.sv
// lcd write checker: watches the config, number and write channels of the lcd segment writer,
// predicts the display writes of every accepted number and compares them in order
// depends on snlcd_pkg for the field widths, the mode codes and the address map
`timescale 1ns / 1ps

module lcd_write_check
  import snlcd_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_valid,
  input  wire                       cfg_ready,
  input  wire  [1:0]                screen_mode,
  input  wire                       in_valid,
  input  wire                       in_stall,
  input  wire  signed [VALUE_W-1:0] value,
  input  wire  [PC_W-1:0]           point_code,
  input  wire                       out_valid,
  input  wire                       out_stall,
  input  wire  [5:0]                lcd_address,
  input  wire  [7:0]                segment_data,
  input  wire                       nibble_write,
  input  wire                       last_write,
  output int                        error_count,
  output int                        writes_pending
);

  typedef struct packed {
    logic [5:0] addr;
    logic [7:0] data;
    logic       nib;
    logic       last;
  } lcd_write_t;

  // segment codes, glyph 0 in the low byte, blank then minus on top
  localparam logic [95:0] LEFT_SEGMENTS = {8'h04, 8'h00, 8'hED, 8'hEF, 8'hE0, 8'hAF,
                                           8'hAD, 8'h6C, 8'hE5, 8'hC7, 8'h60, 8'hEB};
  localparam logic [95:0] RIGHT_SEGMENTS = {8'h40, 8'h00, 8'hDE, 8'hFE, 8'h0E, 8'hFA,
                                            8'hDA, 8'hC6, 8'h5E, 8'h7C, 8'h06, 8'hBE};

  lcd_write_t expected_writes[$];
  mode_t      mode_now;

  function automatic void push_write(input logic [5:0] addr, input logic [7:0] data,
                                     input logic nib);
    lcd_write_t w;
    w.addr = addr;
    w.data = data;
    w.nib  = nib;
    w.last = 1'b0;
    expected_writes.push_back(w);
  endfunction

  function automatic void push_digit(input glyph_t g, input int pos, input bit with_point);
    logic [7:0] seg;
    if (pos < 3) begin
      seg = LEFT_SEGMENTS[g*8 +: 8];
      if (with_point) seg = seg | PT_BIT_A;
    end else begin
      seg = RIGHT_SEGMENTS[g*8 +: 8];
      if (with_point) seg = seg | PT_BIT_B;
    end
    case (pos)
      0: push_write(ADDR_D0, seg, 1'b0);
      1: push_write(ADDR_D1, seg, 1'b0);
      2: begin
        push_write(ADDR_D2_LO, {4'h0, seg[3:0]}, 1'b1);
        push_write(ADDR_D2_HI, {4'h0, seg[7:4]}, 1'b1);
      end
      3: push_write(ADDR_D3, seg, 1'b0);
      4: push_write(ADDR_D4, seg, 1'b0);
      default: push_write(ADDR_D5, seg, 1'b0);
    endcase
  endfunction

  function automatic void predict_number(input logic signed [VALUE_W-1:0] num,
                                         input logic [PC_W-1:0] pc, input mode_t mode);
    int         v;
    int         mag;
    bit         neg;
    glyph_t     digs [DIGIT_COUNT];
    int         top_blank;
    int         point_at;
    lcd_write_t w;
    v = num;
    if (v > 999999) v = 999999;
    if (v < -99999) v = -99999;
    neg = v < 0;
    mag = neg ? -v : v;
    top_blank = -1;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      if (mag != 0) begin
        digs[i] = glyph_t'(mag % 10);
      end else begin
        digs[i] = 4'd0;
        // leading zeros blank unless the point reaches them
        if (int'(pc) < DIGIT_COUNT - 1 - i) begin
          digs[i] = GLYPH_BLANK;
          if (top_blank < 0) top_blank = i;
        end
      end
      mag = mag / 10;
    end
    if (neg) digs[top_blank >= 0 ? top_blank : 0] = GLYPH_MINUS;
    point_at = DIGIT_COUNT - 1;
    if (pc >= PLACES_MIN && pc <= PLACES_MAX) point_at = DIGIT_COUNT - 1 - int'(pc);
    if (pc >= FLASH_BASE && pc <= FLASH_LAST) digs[pc - FLASH_BASE] = GLYPH_BLANK;
    for (int i = 0; i < DIGIT_COUNT; i++) push_digit(digs[i], i, 1'b0);
    if (mode == MODE_CAL) point_at = CAL_POINT_POS;
    if (point_at != DIGIT_COUNT - 1 && (mode == MODE_LIVE || mode == MODE_CAL))
      push_digit(digs[point_at], point_at, 1'b1);
    w = expected_writes.pop_back();
    w.last = 1'b1;
    expected_writes.push_back(w);
  endfunction

  initial begin
    error_count    = 0;
    writes_pending = 0;
    mode_now       = MODE_LIVE;
  end

  always @(posedge clk) begin
    lcd_write_t exp_w;
    if (rst) begin
      mode_now = MODE_LIVE;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) mode_now = mode_t'(screen_mode);
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("write transfer with nothing expected: addr %0d data %02h",
                 lcd_address, segment_data);
          error_count++;
        end else begin
          exp_w = expected_writes.pop_front();
          if (lcd_address !== exp_w.addr) begin
            $error("lcd_address expected %0d got %0d", exp_w.addr, lcd_address);
            error_count++;
          end
          if (segment_data !== exp_w.data) begin
            $error("segment_data expected %02h got %02h", exp_w.data, segment_data);
            error_count++;
          end
          if (nibble_write !== exp_w.nib) begin
            $error("nibble_write expected %0b got %0b", exp_w.nib, nibble_write);
            error_count++;
          end
          if (last_write !== exp_w.last) begin
            $error("last_write expected %0b got %0b", exp_w.last, last_write);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_number(value, point_code, mode_now);
    end
    writes_pending = expected_writes.size();
  end

endmodule

>>> dv/signed_number_to_lcd_segment_writes_test.sv
// top of the lcd segment writer testbench: clock, reset, number and config stimulus
// depends on snlcd_pkg, the signed_number_to_lcd_segment_writes block and lcd_write_check
`timescale 1ns / 1ps

module signed_number_to_lcd_segment_writes_test;
  import snlcd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 120;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [1:0]                 screen_mode;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [VALUE_W-1:0]  value;
  logic [PC_W-1:0]            point_code;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [5:0]                 lcd_address;
  logic [7:0]                 segment_data;
  logic                       nibble_write;
  logic                       last_write;

  int check_errors;
  int writes_pending;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  signed_number_to_lcd_segment_writes dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .screen_mode  (screen_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .point_code   (point_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lcd_address  (lcd_address),
    .segment_data (segment_data),
    .nibble_write (nibble_write),
    .last_write   (last_write)
  );

  lcd_write_check check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .screen_mode    (screen_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (value),
    .point_code     (point_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .lcd_address    (lcd_address),
    .segment_data   (segment_data),
    .nibble_write   (nibble_write),
    .last_write     (last_write),
    .error_count    (check_errors),
    .writes_pending (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_number(input logic signed [VALUE_W-1:0] v, input logic [PC_W-1:0] pc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    point_code <= pc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_valid   <= 1'b1;
    screen_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 30) v = int'($urandom_range(400)) - 200;
    else if (sel < 50) v = $urandom_range(999999);
    else if (sel < 65) v = 100000 + int'($urandom_range(899999));
    else if (sel < 80) v = -int'($urandom_range(99999));
    else if (sel < 90) v = $urandom;
    else begin
      case ($urandom_range(5))
        0: v = 999999;
        1: v = 1000000;
        2: v = -99999;
        3: v = -100000;
        4: v = 1048575;
        default: v = -1048576;
      endcase
    end
    return VALUE_W'(v);
  endfunction

  function automatic logic [PC_W-1:0] pick_point_code();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return PC_W'($urandom_range(PLACES_MAX));
    if (sel < 85) return PC_W'(FLASH_BASE + $urandom_range(FLASH_LAST - FLASH_BASE));
    return PC_W'($urandom_range(31));
  endfunction

  initial begin
    mode_t phase_modes [4];
    int    phase_idle  [4];
    int    phase_stall [4];
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    screen_mode   = MODE_LIVE;
    in_valid      = 1'b0;
    value         = '0;
    point_code    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    phase_modes = '{MODE_CAL, MODE_HIDE, MODE_HIDE_ALT, MODE_LIVE};
    phase_idle  = '{0, 45, 0, 18};
    phase_stall = '{0, 0, 45, 18};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_mode(MODE_LIVE);

    // field extremes, saturation, blanking, minus placement and flash codes
    send_number(21'sd0, 5'd0);
    send_number(21'sd999999, 5'd0);
    send_number(21'sd1000000, 5'd3);
    send_number(21'sd1048575, 5'd0);
    send_number(-21'sd1048576, 5'd0);
    send_number(-21'sd99999, 5'd2);
    send_number(-21'sd100000, 5'd0);
    send_number(-21'sd1, 5'd0);
    send_number(-21'sd7, 5'd3);
    send_number(-21'sd12345, 5'd0);
    send_number(21'sd0, 5'd5);
    send_number(21'sd5, 5'd1);
    send_number(21'sd123, 5'd4);
    send_number(21'sd987654, 5'd2);
    send_number(21'sd42, 5'd20);
    send_number(21'sd42, 5'd21);
    send_number(21'sd42, 5'd22);
    send_number(-21'sd42, 5'd23);
    send_number(21'sd42, 5'd24);
    send_number(21'sd42, 5'd25);
    send_number(21'sd7, 5'd6);
    send_number(21'sd7, 5'd19);
    send_number(21'sd7, 5'd26);
    send_number(-21'sd3, 5'd31);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(phase_modes[ph]);
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender off until the block has emptied
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_number(pick_value(), pick_point_code());
      end
      wait_drained();
    end

    if (check_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/snlcd_pkg.sv
rtl/snlcd_queue.sv
rtl/snlcd_front.sv
rtl/snlcd_back.sv
rtl/signed_number_to_lcd_segment_writes.sv
dv/lcd_write_check.sv
dv/signed_number_to_lcd_segment_writes_test.sv
